>>> sv/imu_stationary_window_gate_macros.svh
// Assertion macros shared by the stationary window gate modules.
`ifndef IMU_STATIONARY_WINDOW_GATE_MACROS_SVH
`define IMU_STATIONARY_WINDOW_GATE_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ISWG_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check an implication whose consequent holds in the next cycle, outside reset.
`define ISWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/iswg_pkg.sv
// Package with types, constants and register indexes for the stationary window gate.
package iswg_pkg;
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int MOTOR_COUNT_DEF  = 4;

    typedef enum logic [2:0] {
        CFG_SPEED_LIMIT  = 3'd0,
        CFG_NORM_LOW     = 3'd1,
        CFG_NORM_HIGH    = 3'd2,
        CFG_ACCEL_VAR    = 3'd3,
        CFG_GYRO_VAR     = 3'd4,
        CFG_MOTOR_MASK   = 3'd5
    } t_cfg_idx;

    // Classification of one item made by the front part.
    typedef enum logic [1:0] {
        CLS_ZERO_MASK = 2'd0,
        CLS_CLEAR     = 2'd1,
        CLS_UPDATE    = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls               cls;
        logic [31:0]        seq;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_ROOT, ST_RANGE, ST_READ, ST_SUB, ST_ADD,
        ST_CHK, ST_CMP, ST_CLR, ST_OUT
    } t_state;
endpackage

>>> sv/iswg_front.sv
// Front part: accepts items, checks motor motion and queues classified jobs.
module iswg_front #(
    parameter int MOTOR_COUNT = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_motor_drive_packed,
    input  logic [63:0]        i_motor_speed_packed,
    input  logic [3:0]         i_motor_speed_valid,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [31:0]        i_sample_seq,
    input  logic [14:0]        i_speed_limit,
    input  logic [3:0]         i_motor_mask,
    output logic               o_job_valid,
    output iswg_pkg::t_job     o_job,
    input  logic               i_job_ready
);
    import iswg_pkg::*;
    `include "imu_stationary_window_gate_macros.svh"

    // Two-entry queue
    t_job        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        motion;
    logic        push, pop;
    t_job        job;
    logic signed [15:0] drv, spd;
    logic [15:0] mag;

    always_comb begin
        motion = 1'b0;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            drv = i_motor_drive_packed[m*16 +: 16];
            spd = i_motor_speed_packed[m*16 +: 16];
            mag = spd[15] ? 16'(-spd) : 16'(spd);
            if (drv != 16'sd0) motion = 1'b1;
            if (i_motor_mask[m] && (!i_motor_speed_valid[m] || mag > {1'b0, i_speed_limit}))
                motion = 1'b1;
        end
    end

    always_comb begin
        job.cls = (i_motor_mask == 4'd0) ? CLS_ZERO_MASK : (motion ? CLS_CLEAR : CLS_UPDATE);
        job.seq = i_sample_seq;
        job.ax = i_accel_x; job.ay = i_accel_y; job.az = i_accel_z;
        job.gx = i_gyro_x;  job.gy = i_gyro_y;  job.gz = i_gyro_z;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    // Write and advance queue pointers
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    `ISWG_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2, "queue overflow")
    `ISWG_ASSERT_NEXT(a_push_full, i_clk, i_rst_n, push && !pop && r_cnt == 2'd1,
        r_cnt == 2'd2, "queue count wrong")
    `ISWG_ASSERT_IMPL(a_ptr, i_clk, i_rst_n, r_cnt == 2'd0 || r_cnt == 2'd2,
        r_wp == r_rp, "queue pointers out of step")
endmodule

>>> sv/iswg_back.sv
// Back part: magnitude root, window update and variance test, one job at a time.
module iswg_back #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  iswg_pkg::t_job i_job,
    output logic           o_job_ready,
    input  logic [15:0]    i_norm_low,
    input  logic [15:0]    i_norm_high,
    input  logic [31:0]    i_accel_var,
    input  logic [31:0]    i_gyro_var,
    output logic           o_valid,
    output logic           o_stationary,
    input  logic           i_ready
);
    import iswg_pkg::*;
    `include "imu_stationary_window_gate_macros.svh"

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int LW = $clog2(WINDOW_DEPTH);
    localparam logic [FW-1:0] WFULL = FW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] WLAST = AW'(WINDOW_DEPTH - 1);
    localparam int SW  = 16 + AW + 1;
    localparam int QW  = 32 + AW + 1;

    t_state r_st, n_st;
    t_job   r_job;
    logic [33:0] r_rem;
    logic [33:0] r_root;
    logic [33:0] r_bit;
    logic [15:0] r_norm;
    logic [AW-1:0] r_pos;
    logic [FW-1:0] r_fill;
    logic [SW-1:0] r_asum;
    logic [QW-1:0] r_aq;
    logic signed [SW-1:0] r_gs [3];
    logic [QW-1:0] r_gq [3];
    logic [31:0] r_last;
    logic        r_seen;
    logic [1:0]  r_ch;
    logic        r_ok;
    logic        r_out_v, r_out_s;
    logic [15:0] r_old_a;
    logic [47:0] r_old_g;
    logic [3:0]  r_sq;
    logic [33:0] r_acc;
    logic [15:0] r_mop_a, r_mop_b;
    logic [31:0] r_prod;

    logic [15:0] mem_a [WINDOW_DEPTH];
    logic [47:0] mem_g [WINDOW_DEPTH];

    function automatic logic [SW-1:0] gabs_n(input logic signed [SW-1:0] v);
        gabs_n = v[SW-1] ? SW'(-v) : SW'(v);
    endfunction

    // Accel axis squares via one shared 16x16 multiplier
    logic signed [15:0] sq_in;
    logic [15:0] sq_mag;
    always_comb begin
        case (r_sq)
            4'd0: sq_in = r_job.ax;
            4'd1: sq_in = r_job.ay;
            default: sq_in = r_job.az;
        endcase
        sq_mag = sq_in[15] ? 16'(-sq_in) : 16'(sq_in);
    end

    // Variance check operands for the current channel
    logic [SW-1:0] c_sum;
    logic [QW-1:0] c_sq;
    logic [31:0]   c_lim;
    logic [SW-1:0] gabs;
    always_comb begin
        gabs = r_gs[0][SW-1] ? SW'(-r_gs[0]) : SW'(r_gs[0]);
        case (r_ch)
            2'd0: begin c_sum = r_asum; c_sq = r_aq; c_lim = i_accel_var; end
            2'd1: begin
                gabs = r_gs[0][SW-1] ? SW'(-r_gs[0]) : SW'(r_gs[0]);
                c_sum = gabs; c_sq = r_gq[0]; c_lim = i_gyro_var;
            end
            2'd2: begin
                gabs = r_gs[1][SW-1] ? SW'(-r_gs[1]) : SW'(r_gs[1]);
                c_sum = gabs; c_sq = r_gq[1]; c_lim = i_gyro_var;
            end
            default: begin
                gabs = r_gs[2][SW-1] ? SW'(-r_gs[2]) : SW'(r_gs[2]);
                c_sum = gabs; c_sq = r_gq[2]; c_lim = i_gyro_var;
            end
        endcase
    end

    // W*sumsq - sum^2 <= lim*W^2; W is a constant, so the products by W and W^2 on
    // either side of the test reduce to shifts and adds, one channel per cycle.
    logic [2*SW-1:0] r_sumsq2;
    logic [QW+LW+1:0] spread_l;
    logic [QW+LW+1:0] spread_r;
    assign spread_l = (QW+LW+2)'(c_sq) * (QW+LW+2)'(WINDOW_DEPTH);
    assign spread_r = (QW+LW+2)'(r_sumsq2)
                      + (QW+LW+2)'(c_lim) * (QW+LW+2)'(WINDOW_DEPTH * WINDOW_DEPTH);

    logic accept;
    assign o_job_ready = (r_st == ST_IDLE) && !r_out_v;
    assign accept      = i_job_valid && o_job_ready;
    assign o_valid      = r_out_v;
    assign o_stationary = r_out_s;

    logic [47:0] new_g;
    assign new_g = {r_job.gz, r_job.gy, r_job.gx};

    // Next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (accept) begin
                          if (i_job.cls == CLS_ZERO_MASK) n_st = ST_OUT;
                          else if (i_job.cls == CLS_CLEAR) n_st = ST_CLR;
                          else n_st = ST_SQ;
                      end
            ST_SQ:    if (r_sq == 4'd4) n_st = ST_ROOT;
            ST_ROOT:  if (r_bit == 34'd0) n_st = ST_RANGE;
            ST_RANGE: begin
                          if (r_norm < i_norm_low || r_norm > i_norm_high) n_st = ST_CLR;
                          else if (r_seen && r_last == r_job.seq) n_st = ST_CHK;
                          else n_st = ST_READ;
                      end
            ST_READ:  n_st = ST_SUB;
            ST_SUB:   n_st = ST_ADD;
            ST_ADD:   n_st = ST_CHK;
            ST_CHK:   n_st = (r_fill < WFULL) ? ST_OUT : ST_CMP;
            ST_CMP:   if (!r_ok || r_ch == 2'd3) n_st = ST_OUT;
                      else n_st = ST_CMP;
            ST_CLR:   n_st = ST_OUT;
            ST_OUT:   n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // Window memory
    always_ff @(posedge i_clk) begin
        if (r_st == ST_READ) begin
            r_old_a <= mem_a[r_pos];
            r_old_g <= mem_g[r_pos];
        end
        if (r_st == ST_ADD) begin
            mem_a[r_pos] <= r_norm;
            mem_g[r_pos] <= new_g;
        end
    end

    // Datapath and control registers
    always_ff @(posedge i_clk) begin
        if (accept) r_job <= i_job;
        r_prod <= r_mop_a * r_mop_b;
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_pos <= '0; r_fill <= '0; r_asum <= '0; r_aq <= '0;
            for (int a = 0; a < 3; a++) begin r_gs[a] <= '0; r_gq[a] <= '0; end
            r_last <= '0; r_seen <= 1'b0; r_out_v <= 1'b0; r_out_s <= 1'b0;
            r_sq <= '0; r_ch <= '0; r_ok <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_out_v && i_ready) r_out_v <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    r_sq <= '0; r_acc <= '0; r_ok <= 1'b0; r_ch <= '0;
                    r_mop_a <= '0; r_mop_b <= '0;
                end
                ST_SQ: begin
                    // Pipeline: load operand, accumulate previous product
                    if (r_sq != 4'd0) r_acc <= r_acc + 34'(r_prod);
                    r_mop_a <= sq_mag; r_mop_b <= sq_mag;
                    r_sq <= r_sq + 4'd1;
                    if (r_sq == 4'd4) begin
                        r_rem  <= r_acc + 34'(r_prod);
                        r_root <= '0;
                        r_bit  <= 34'h1 << 32;
                    end
                end
                ST_ROOT: begin
                    // One result bit per cycle
                    if (r_bit != 34'd0) begin
                        if (r_rem >= r_root + r_bit) begin
                            r_rem  <= r_rem - (r_root + r_bit);
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end else begin
                        r_norm <= r_root[15:0];
                    end
                end
                ST_SUB: begin
                    if (r_fill >= WFULL) begin
                        r_asum <= r_asum - SW'(r_old_a);
                        r_aq   <= r_aq - QW'(32'(r_old_a) * 32'(r_old_a));
                        for (int a = 0; a < 3; a++) begin
                            r_gs[a] <= r_gs[a] - SW'($signed(r_old_g[a*16 +: 16]));
                            r_gq[a] <= r_gq[a] - QW'(32'($signed(r_old_g[a*16 +: 16])
                                                   * $signed(r_old_g[a*16 +: 16])));
                        end
                    end else begin
                        r_fill <= r_fill + FW'(1);
                    end
                end
                ST_ADD: begin
                    r_asum <= r_asum + SW'(r_norm);
                    r_aq   <= r_aq + QW'(32'(r_norm) * 32'(r_norm));
                    for (int a = 0; a < 3; a++) begin
                        r_gs[a] <= r_gs[a] + SW'($signed(new_g[a*16 +: 16]));
                        r_gq[a] <= r_gq[a] + QW'(32'($signed(new_g[a*16 +: 16])
                                               * $signed(new_g[a*16 +: 16])));
                    end
                    r_pos  <= (r_pos == WLAST) ? '0 : r_pos + AW'(1);
                    r_last <= r_job.seq;
                    r_seen <= 1'b1;
                end
                ST_CHK: begin
                    r_ok <= 1'b1; r_ch <= '0;
                    r_sumsq2 <= (2*SW)'(r_asum) * (2*SW)'(r_asum);
                end
                ST_CMP: begin
                    if (spread_l > spread_r) r_ok <= 1'b0;
                    r_ch <= r_ch + 2'd1;
                    case (r_ch)
                        2'd0: r_sumsq2 <= (2*SW)'(gabs_n(r_gs[0])) * (2*SW)'(gabs_n(r_gs[0]));
                        2'd1: r_sumsq2 <= (2*SW)'(gabs_n(r_gs[1])) * (2*SW)'(gabs_n(r_gs[1]));
                        default: r_sumsq2 <= (2*SW)'(gabs_n(r_gs[2])) * (2*SW)'(gabs_n(r_gs[2]));
                    endcase
                end
                ST_CLR: begin
                    r_pos <= '0; r_fill <= '0; r_asum <= '0; r_aq <= '0;
                    for (int a = 0; a < 3; a++) begin r_gs[a] <= '0; r_gq[a] <= '0; end
                    r_last <= r_job.seq; r_seen <= 1'b1; r_ok <= 1'b0;
                end
                ST_OUT: begin
                    r_out_v <= 1'b1;
                    r_out_s <= r_ok && (r_fill >= WFULL) && (r_job.cls == CLS_UPDATE);
                end
                default: ;
            endcase
        end
    end

    `ISWG_ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= WFULL, "fill beyond depth")
    `ISWG_ASSERT_NEXT(a_clr_empty, i_clk, i_rst_n, r_st == ST_CLR,
        r_fill == '0 && r_asum == '0, "clear left evidence")
    `ISWG_ASSERT_IMPL(a_busy, i_clk, i_rst_n, r_st != ST_IDLE, !o_job_ready,
        "job taken while busy")
endmodule

>>> sv/imu_stationary_window_gate.sv
// Top level of the IMU stationary window gate: config registers, front, back.
//  channel | signals                                   | direction
//  in      | i_valid/o_ready + sample fields           | item in
//  out     | o_valid/i_ready + o_stationary            | result out
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data           | register write
// An update item, once the back part takes it, passes through squaring of the accel
// axes, the one-bit-per-cycle square root, range check and window update, up to 4
// variance compares and a register for the result. A cleared item goes through
// the clear state, a zero-mask item straight to the output. Reset is synchronous and
// clears the window sums and fill count; window memory needs no clearing.
// The front queue holds two items, so up to two items are taken while the back stalls.
module imu_stationary_window_gate #(
    parameter int WINDOW_DEPTH = iswg_pkg::WINDOW_DEPTH_DEF,
    parameter int MOTOR_COUNT  = iswg_pkg::MOTOR_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_motor_drive_packed,
    input  logic [63:0]        i_motor_speed_packed,
    input  logic [3:0]         i_motor_speed_valid,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [31:0]        i_sample_seq,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_stationary,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import iswg_pkg::*;

    logic [14:0] r_speed_limit;
    logic [15:0] r_norm_low, r_norm_high;
    logic [31:0] r_accel_var, r_gyro_var;
    logic [3:0]  r_mask;
    logic        job_valid, job_ready;
    t_job        job;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_limit <= 15'd20;
            r_norm_low    <= 16'd950;
            r_norm_high   <= 16'd1050;
            r_accel_var   <= 32'd400;
            r_gyro_var    <= 32'd25;
            r_mask        <= 4'd15;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[14:0];
                CFG_NORM_LOW:    r_norm_low    <= i_cfg_data[15:0];
                CFG_NORM_HIGH:   r_norm_high   <= i_cfg_data[15:0];
                CFG_ACCEL_VAR:   r_accel_var   <= i_cfg_data;
                CFG_GYRO_VAR:    r_gyro_var    <= i_cfg_data;
                CFG_MOTOR_MASK:  r_mask        <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    iswg_front #(.MOTOR_COUNT(MOTOR_COUNT)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_motor_drive_packed, .i_motor_speed_packed, .i_motor_speed_valid,
        .i_accel_x, .i_accel_y, .i_accel_z, .i_gyro_x, .i_gyro_y, .i_gyro_z,
        .i_sample_seq, .i_speed_limit(r_speed_limit), .i_motor_mask(r_mask),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready)
    );

    iswg_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .i_job(job), .o_job_ready(job_ready),
        .i_norm_low(r_norm_low), .i_norm_high(r_norm_high),
        .i_accel_var(r_accel_var), .i_gyro_var(r_gyro_var),
        .o_valid, .o_stationary, .i_ready
    );
endmodule
